// ===== sv/pfde_pkg.sv =====
// ----------------------------------------------------------------------------
// pfde_pkg: shared definitions for the page framebuffer drawing engine
// Display geometry, command codes, controller/datapath interface structs
// and the 5x8 glyph table.
// ----------------------------------------------------------------------------
`default_nettype none
package pfde_pkg;
	localparam int DISPLAY_WIDTH  = 128;
	localparam int DISPLAY_HEIGHT = 64;
	localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
	localparam int STORE_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;
	localparam int ADDR_W         = $clog2(STORE_BYTES);
	localparam int COORD_W        = 12;
	localparam int ERR_W          = 14;
	localparam int GLYPH_FIRST    = 32;
	localparam int GLYPH_LAST     = 90;
	localparam int GLYPH_COLS     = 5;
	localparam int GLYPH_ROWS     = 8;
	localparam int GLYPH_COUNT    = 59;

	typedef enum logic [2:0] {
		OP_CLEAR = 3'd0,
		OP_PIXEL = 3'd1,
		OP_LINE  = 3'd2,
		OP_RECT  = 3'd3,
		OP_FILL  = 3'd4,
		OP_GLYPH = 3'd5,
		OP_READ  = 3'd6,
		OP_NONE  = 3'd7
	} op_t;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [ERR_W-1:0]   err_t;

	typedef struct packed {
		logic capture;
		logic setup;
		logic seg_load;
		logic step;
		logic pix_rd;
		logic pix_wr;
		logic clr_wr;
		logic rd_issue;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic empty;
		logic walk_last;
		logic seg_more;
		logic pix_ok;
		logic clr_last;
	} sts_t;

	// Columns 0..4 from the most significant byte down; bit j is row j.
	localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
		40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
		40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
		40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
		40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
		40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
		40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
		40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
		40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
		40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
		40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
		40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
		40'h6314081463, 40'h0304780403, 40'h6151494543
	};

	function automatic logic [7:0] glyph_col(input logic [5:0] g, input logic [2:0] c);
		logic [39:0] bits;
		bits = GLYPH_ROM[g];
		if (c > 3'd4)
			return 8'h00;
		return bits[39 - 8 * int'(c) -: 8];
	endfunction
endpackage
`default_nettype wire

// ===== sv/pfde_ram.sv =====
// ----------------------------------------------------------------------------
// pfde_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module pfde_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/pfde_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfde_ctrl: command sequencer
// Walks each command through clear sweep, pixel read-modify-write and
// result hand-off; drives the datapath by command strobes.
// ----------------------------------------------------------------------------
`default_nettype none
module pfde_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output pfde_pkg::cmd_t     cmd,
	input  wire pfde_pkg::sts_t sts
);
	import pfde_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_CLEAR  = 7'b0000010,
		S_SETUP  = 7'b0000100,
		S_PLOT   = 7'b0001000,
		S_WRITE  = 7'b0010000,
		S_SEG    = 7'b0100000,
		S_FINISH = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   boot_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_SETUP;
				end
			end
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last)
					state_d = boot_q ? S_IDLE : S_FINISH;
			end
			S_SETUP: begin
				unique case (sts.op)
					OP_CLEAR: state_d = S_CLEAR;
					OP_READ: begin
						cmd.rd_issue = 1'b1;
						state_d      = S_FINISH;
					end
					OP_NONE: state_d = S_FINISH;
					default: begin
						cmd.setup = 1'b1;
						state_d   = sts.empty ? S_FINISH : S_PLOT;
					end
				endcase
			end
			S_PLOT, S_WRITE: begin
				if (state_q == S_PLOT && sts.pix_ok) begin
					cmd.pix_rd = 1'b1;
					state_d    = S_WRITE;
				end else begin
					cmd.pix_wr = (state_q == S_WRITE);
					if (!sts.walk_last) begin
						cmd.step = 1'b1;
						state_d  = S_PLOT;
					end else begin
						state_d = sts.seg_more ? S_SEG : S_FINISH;
					end
				end
			end
			S_SEG: begin
				cmd.seg_load = 1'b1;
				state_d      = S_PLOT;
			end
			S_FINISH: begin
				// The previous result may still be waiting on the output side.
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			boot_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR && sts.clr_last)
				boot_q <= 1'b0;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== sv/pfde_datapath.sv =====
// ----------------------------------------------------------------------------
// pfde_datapath: pixel walker and framebuffer access
// Holds the command operands, walks Bresenham lines, raster fills and
// glyph cells one pixel at a time, and owns the framebuffer RAM.
// ----------------------------------------------------------------------------
`default_nettype none
module pfde_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pfde_pkg::cmd_t      cmd,
	output pfde_pkg::sts_t           sts,
	input  wire logic [2:0]          op,
	input  wire logic signed [9:0]   x_start,
	input  wire logic signed [9:0]   y_start,
	input  wire logic signed [9:0]   x_end,
	input  wire logic signed [9:0]   y_end,
	input  wire logic signed [9:0]   rect_width,
	input  wire logic signed [9:0]   rect_height,
	input  wire logic                color,
	input  wire logic [7:0]          char_code,
	input  wire logic [9:0]          read_index,
	output logic [7:0]               read_data,
	output logic [2:0]               done_op
);
	import pfde_pkg::*;

	// Operands captured when the transaction is accepted.
	op_t        op_q;
	coord_t     xs_q, ys_q, xe_q, ye_q, xw_q, yh_q;
	coord_t     fx0_q, fx1_q, fy0_q, fy1_q;
	logic       color_q;
	logic [5:0] gidx_q;
	logic       rd_ok_q;
	logic [ADDR_W-1:0] ridx_q;

	// Walk state.
	coord_t     x_q, y_q, tx_q, ty_q;
	err_t       dx_q, dy_q, err_q;
	logic       sxn_q, syn_q;
	logic [1:0] seg_q;
	logic [ADDR_W-1:0] clr_q;

	logic [7:0] read_data_q;
	logic [2:0] done_op_q;

	coord_t xs_in, ys_in, xw_in, yh_in;
	assign xs_in = coord_t'(x_start);
	assign ys_in = coord_t'(y_start);
	assign xw_in = xs_in + coord_t'(rect_width);
	assign yh_in = ys_in + coord_t'(rect_height);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op_t'(op);
			xs_q    <= xs_in;
			ys_q    <= ys_in;
			xe_q    <= coord_t'(x_end);
			ye_q    <= coord_t'(y_end);
			xw_q    <= xw_in;
			yh_q    <= yh_in;
			fx0_q   <= (xs_in < 0) ? coord_t'(0) : xs_in;
			fy0_q   <= (ys_in < 0) ? coord_t'(0) : ys_in;
			fx1_q   <= (xw_in > coord_t'(DISPLAY_WIDTH)) ? coord_t'(DISPLAY_WIDTH) : xw_in;
			fy1_q   <= (yh_in > coord_t'(DISPLAY_HEIGHT)) ? coord_t'(DISPLAY_HEIGHT) : yh_in;
			color_q <= color;
			gidx_q  <= (char_code < 8'(GLYPH_FIRST) || char_code > 8'(GLYPH_LAST))
				? 6'd0 : 6'(char_code - 8'(GLYPH_FIRST));
			rd_ok_q <= (int'(read_index) < STORE_BYTES);
			ridx_q  <= ADDR_W'(read_index);
		end
	end

	// Segment endpoints; an outline is four lines around the corners.
	logic [1:0] seg_n;
	coord_t     ax, ay, bx, by;
	assign seg_n = cmd.setup ? 2'd0 : seg_q + 2'd1;

	always_comb begin
		ax = xs_q; ay = ys_q; bx = xe_q; by = ye_q;
		if (op_q == OP_RECT) begin
			unique case (seg_n)
				2'd0: begin ax = xs_q; ay = ys_q; bx = xw_q; by = ys_q; end
				2'd1: begin ax = xw_q; ay = ys_q; bx = xw_q; by = yh_q; end
				2'd2: begin ax = xw_q; ay = yh_q; bx = xs_q; by = yh_q; end
				2'd3: begin ax = xs_q; ay = yh_q; bx = xs_q; by = ys_q; end
			endcase
		end
	end

	err_t ddx, ddy, adx, ady;
	assign ddx = err_t'(bx) - err_t'(ax);
	assign ddy = err_t'(by) - err_t'(ay);
	assign adx = (ddx < 0) ? -ddx : ddx;
	assign ady = (ddy < 0) ? -ddy : ddy;

	// One Bresenham step, both decisions taken on the old error term.
	logic signed [ERR_W:0] e2, dxe, dyn;
	logic  go_x, go_y;
	assign e2   = {err_q, 1'b0};
	assign dxe  = (ERR_W+1)'(dx_q);
	assign dyn  = -(ERR_W+1)'(dy_q);
	assign go_x = (e2 > dyn);
	assign go_y = (e2 < dxe);

	logic is_line, is_raster;
	assign is_line   = (op_q == OP_LINE) || (op_q == OP_RECT);
	assign is_raster = (op_q == OP_FILL) || (op_q == OP_GLYPH);

	coord_t row_first, row_last, col_last;
	assign row_first = (op_q == OP_FILL) ? fy0_q : ys_q;
	assign row_last  = (op_q == OP_FILL) ? fy1_q - coord_t'(1) : ys_q + coord_t'(GLYPH_ROWS - 1);
	assign col_last  = (op_q == OP_FILL) ? fx1_q - coord_t'(1) : xs_q + coord_t'(GLYPH_COLS - 1);

	always_ff @(posedge clk) begin
		if (cmd.setup || cmd.seg_load) begin
			seg_q <= seg_n;
			if (is_line) begin
				x_q   <= ax;
				y_q   <= ay;
				tx_q  <= bx;
				ty_q  <= by;
				dx_q  <= adx;
				dy_q  <= ady;
				err_q <= adx - ady;
				sxn_q <= !(ax < bx);
				syn_q <= !(ay < by);
			end else begin
				x_q <= (op_q == OP_FILL) ? fx0_q : xs_q;
				y_q <= (op_q == OP_FILL) ? fy0_q : ys_q;
			end
		end else if (cmd.step) begin
			if (is_line) begin
				err_q <= err_q - (go_x ? dy_q : err_t'(0)) + (go_y ? dx_q : err_t'(0));
				if (go_x)
					x_q <= sxn_q ? x_q - coord_t'(1) : x_q + coord_t'(1);
				if (go_y)
					y_q <= syn_q ? y_q - coord_t'(1) : y_q + coord_t'(1);
			end else if (y_q == row_last) begin
				y_q <= row_first;
				x_q <= x_q + coord_t'(1);
			end else begin
				y_q <= y_q + coord_t'(1);
			end
		end
	end

	// Pixel visibility, byte address and bit mask.
	logic       glyph_bit, pix_en, on_screen, pix_val;
	logic [7:0] gcol, mask, rdata, wdata;
	logic [ADDR_W-1:0] pix_addr;

	assign gcol      = glyph_col(gidx_q, 3'(x_q - xs_q));
	assign glyph_bit = gcol[3'(y_q - ys_q)];
	assign pix_en    = (op_q == OP_GLYPH) ? glyph_bit : 1'b1;
	assign pix_val   = (op_q == OP_PIXEL) ? color_q : 1'b1;
	assign on_screen = (x_q >= 0) && (x_q < coord_t'(DISPLAY_WIDTH)) &&
		(y_q >= 0) && (y_q < coord_t'(DISPLAY_HEIGHT));
	assign pix_addr  = ADDR_W'((int'(y_q) >>> 3) * DISPLAY_WIDTH + int'(x_q));
	assign mask      = 8'(1) << y_q[2:0];
	assign wdata     = cmd.clr_wr ? 8'h00 : (pix_val ? (rdata | mask) : (rdata & ~mask));

	pfde_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
		.clk   (clk),
		.we    (cmd.clr_wr || cmd.pix_wr),
		.waddr (cmd.clr_wr ? clr_q : pix_addr),
		.wdata (wdata),
		.re    (cmd.pix_rd || cmd.rd_issue),
		.raddr (cmd.rd_issue ? ridx_q : pix_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_q <= sts.clr_last ? '0 : clr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			read_data_q <= (op_q == OP_READ && rd_ok_q) ? rdata : 8'h00;
			done_op_q   <= op_q;
		end
	end

	always_comb begin
		sts.op        = op_q;
		sts.empty     = (op_q == OP_FILL) && ((fx0_q >= fx1_q) || (fy0_q >= fy1_q));
		sts.pix_ok    = pix_en && on_screen;
		sts.seg_more  = (op_q == OP_RECT) && (seg_q != 2'd3);
		sts.clr_last  = (clr_q == ADDR_W'(STORE_BYTES - 1));
		if (is_line)
			sts.walk_last = (x_q == tx_q) && (y_q == ty_q);
		else if (is_raster)
			sts.walk_last = (x_q == col_last) && (y_q == row_last);
		else
			sts.walk_last = 1'b1;
	end

	assign read_data = read_data_q;
	assign done_op   = done_op_q;
endmodule
`default_nettype wire

// ===== sv/page_framebuffer_drawing_engine.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_drawing_engine: 2D drawing on a paged monochrome store
// Pixel, line, outline, fill, glyph, clear and byte read commands on a
// framebuffer of 8-row pages, one byte per column per page.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   op, x_start .. read_index
//   output    out_valid / out_ready read_data, done_op
//
// Each drawn pixel is read, then written back modified, through the
// single-port-pair store; skipped or clipped pixels are neither read nor
// written. Clear writes one byte per cycle. After reset the same clearing
// pass runs with in_ready low. A result waits in an output register, so
// the next command is accepted while out_ready is low.
// ----------------------------------------------------------------------------
`default_nettype none
module page_framebuffer_drawing_engine (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [2:0]        op,
	input  wire logic signed [9:0] x_start,
	input  wire logic signed [9:0] y_start,
	input  wire logic signed [9:0] x_end,
	input  wire logic signed [9:0] y_end,
	input  wire logic signed [9:0] rect_width,
	input  wire logic signed [9:0] rect_height,
	input  wire logic              color,
	input  wire logic [7:0]        char_code,
	input  wire logic [9:0]        read_index,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             read_data,
	output logic [2:0]             done_op
);
	import pfde_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pfde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pfde_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.x_start     (x_start),
		.y_start     (y_start),
		.x_end       (x_end),
		.y_end       (y_end),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.color       (color),
		.char_code   (char_code),
		.read_index  (read_index),
		.read_data   (read_data),
		.done_op     (done_op)
	);
endmodule
`default_nettype wire

// ===== sv/pfde_checker.sv =====
// ----------------------------------------------------------------------------
// pfde_checker: port-level checks for the drawing engine
// Watches the two channels of the top level over time.
// ----------------------------------------------------------------------------
`default_nettype none
module pfde_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic [2:0]        op,
	input wire logic signed [9:0] x_start,
	input wire logic signed [9:0] y_start,
	input wire logic signed [9:0] x_end,
	input wire logic signed [9:0] y_end,
	input wire logic signed [9:0] rect_width,
	input wire logic signed [9:0] rect_height,
	input wire logic              color,
	input wire logic [7:0]        char_code,
	input wire logic [9:0]        read_index,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [7:0]        read_data,
	input wire logic [2:0]        done_op
);
	import pfde_pkg::*;

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(done_op))
		else $error("result changed while stalled");

	// Only a read transaction carries data.
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_op != OP_READ |-> read_data == 8'h00)
		else $error("nonzero read_data on a non-read result");

	// One command at a time: the engine is busy right after taking one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction accepted back to back");
endmodule

bind page_framebuffer_drawing_engine pfde_checker u_pfde_checker (.*);
`default_nettype wire

// ===== verif/page_framebuffer_drawing_engine_test.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_drawing_engine_test: self-checking bench for the engine
// Drives drawing and read commands with random gaps, keeps a shadow copy of
// the paged framebuffer, and compares every result against it in order.
// ----------------------------------------------------------------------------
`default_nettype none
module page_framebuffer_drawing_engine_test;
	import pfde_pkg::*;

	typedef struct {
		logic [2:0]        op;
		logic signed [9:0] xs, ys, xe, ye, w, h;
		logic              color;
		logic [7:0]        code;
		logic [9:0]        ridx;
	} draw_cmd_t;

	typedef struct {
		logic [7:0] data;
		logic [2:0] op;
	} done_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [2:0] op;
	logic signed [9:0] x_start, y_start, x_end, y_end, rect_width, rect_height;
	logic color;
	logic [7:0] char_code;
	logic [9:0] read_index;
	logic [7:0] read_data;
	logic [2:0] done_op;

	logic [7:0] shadow_fb [STORE_BYTES];
	done_t      pending_done [$];
	int         errors = 0;
	bit         no_idle = 0;
	int         last_x = 0, last_y = 0;

	page_framebuffer_drawing_engine dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .x_start(x_start), .y_start(y_start), .x_end(x_end), .y_end(y_end),
		.rect_width(rect_width), .rect_height(rect_height), .color(color),
		.char_code(char_code), .read_index(read_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.read_data(read_data), .done_op(done_op)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#240_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic void set_px(int x, int y, bit on);
		int idx;
		if (x < 0 || x >= DISPLAY_WIDTH || y < 0 || y >= DISPLAY_HEIGHT)
			return;
		idx = (y / 8) * DISPLAY_WIDTH + x;
		shadow_fb[idx][y % 8] = on;
	endfunction

	function automatic void walk_line(int xa, int ya, int xb, int yb);
		int dx, dy, sx, sy, err, e2;
		dx = xb > xa ? xb - xa : xa - xb;
		dy = yb > ya ? yb - ya : ya - yb;
		sx = xa < xb ? 1 : -1;
		sy = ya < yb ? 1 : -1;
		err = dx - dy;
		forever begin
			set_px(xa, ya, 1);
			if (xa == xb && ya == yb)
				break;
			e2 = 2 * err;
			if (e2 > -dy) begin
				err -= dy;
				xa += sx;
			end
			if (e2 < dx) begin
				err += dx;
				ya += sy;
			end
		end
	endfunction

	// Applies one command to the shadow store and returns the byte it reports.
	function automatic logic [7:0] apply_cmd(draw_cmd_t c);
		int x, y, w, h, x1, y1, g;
		logic [7:0] bits;
		x = c.xs;
		y = c.ys;
		w = c.w;
		h = c.h;
		case (op_t'(c.op))
			OP_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
			OP_PIXEL: set_px(x, y, c.color);
			OP_LINE: walk_line(x, y, c.xe, c.ye);
			OP_RECT: begin
				walk_line(x, y, x + w, y);
				walk_line(x + w, y, x + w, y + h);
				walk_line(x + w, y + h, x, y + h);
				walk_line(x, y + h, x, y);
			end
			OP_FILL: begin
				x1 = x + w > DISPLAY_WIDTH ? DISPLAY_WIDTH : x + w;
				y1 = y + h > DISPLAY_HEIGHT ? DISPLAY_HEIGHT : y + h;
				for (int i = (x < 0 ? 0 : x); i < x1; i++)
					for (int j = (y < 0 ? 0 : y); j < y1; j++)
						set_px(i, j, 1);
			end
			OP_GLYPH: begin
				g = (c.code < GLYPH_FIRST || c.code > GLYPH_LAST) ? 0 : c.code - GLYPH_FIRST;
				for (int i = 0; i < GLYPH_COLS; i++) begin
					bits = GLYPH_ROM[g][39 - 8 * i -: 8];
					for (int j = 0; j < GLYPH_ROWS; j++)
						if (bits[j])
							set_px(x + i, y + j, 1);
				end
			end
			OP_READ: return (c.ridx < STORE_BYTES) ? shadow_fb[c.ridx] : 8'h00;
			default: ;
		endcase
		return 8'h00;
	endfunction

	function automatic int pick_gap();
		return no_idle ? 0 : $urandom_range(0, 19);
	endfunction

	// Starts at a rising edge and returns at the edge that took the transaction.
	task automatic send_cmd(draw_cmd_t c);
		int gap;
		bit ready_seen;
		done_t d;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= c.op;
		x_start <= c.xs;
		y_start <= c.ys;
		x_end <= c.xe;
		y_end <= c.ye;
		rect_width <= c.w;
		rect_height <= c.h;
		color <= c.color;
		char_code <= c.code;
		read_index <= c.ridx;
		do begin
			@(negedge clk);
			ready_seen = in_ready;
			@(posedge clk);
		end while (!ready_seen);
		d.data = apply_cmd(c);
		d.op = c.op;
		pending_done.push_back(d);
		if (c.op != OP_READ && c.op != OP_CLEAR) begin
			last_x = c.xs;
			last_y = c.ys;
		end
	endtask

	initial begin
		int stall;
		bit took;
		logic [7:0] got_data;
		logic [2:0] got_op;
		done_t want;
		@(posedge arst_n);
		forever begin
			stall = pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(negedge clk);
				took = out_valid && out_ready;
				got_data = read_data;
				got_op = done_op;
				@(posedge clk);
			end while (!took);
			if (pending_done.size() == 0) begin
				errors++;
				$display("%0t unexpected result: read_data %h done_op %0d", $time,
					got_data, got_op);
			end else begin
				want = pending_done.pop_front();
				if (got_data !== want.data) begin
					errors++;
					$display("%0t read_data mismatch: expected %h actual %h", $time,
						want.data, got_data);
				end
				if (got_op !== want.op) begin
					errors++;
					$display("%0t done_op mismatch: expected %0d actual %0d", $time,
						want.op, got_op);
				end
			end
		end
	end

	function automatic draw_cmd_t blank_cmd(op_t o);
		draw_cmd_t c;
		c = '{op: o, xs: 0, ys: 0, xe: 0, ye: 0, w: 0, h: 0, color: 0, code: 0, ridx: 0};
		return c;
	endfunction

	task automatic read_at(int x, int y);
		draw_cmd_t c;
		c = blank_cmd(OP_READ);
		c.ridx = 10'(((y & 63) / 8) * DISPLAY_WIDTH + (x & 127));
		send_cmd(c);
	endtask

	function automatic logic signed [9:0] near_coord(int lo, int hi);
		if ($urandom_range(0, 15) == 0)
			return 10'($urandom);
		return 10'($urandom_range(0, hi - lo) + lo);
	endfunction

	task automatic test_pixels();
		draw_cmd_t c;
		c = blank_cmd(OP_PIXEL);
		c.color = 1;
		c.xs = 127; c.ys = 63; send_cmd(c); read_at(127, 63);
		c.xs = 0; c.ys = 0; send_cmd(c);
		c.xs = -512; c.ys = 511; send_cmd(c);
		c.xs = 128; c.ys = 64; send_cmd(c);
		c.xs = 127; c.ys = 63; c.color = 0; send_cmd(c); read_at(127, 63);
		read_at(0, 0);
	endtask

	task automatic test_shapes();
		draw_cmd_t c;
		c = blank_cmd(OP_LINE);
		c.xs = -20; c.ys = 70; c.xe = 140; c.ye = -5; send_cmd(c);
		c.xs = 30; c.ys = 10; c.xe = 30; c.ye = 10; send_cmd(c);
		read_at(30, 10);
		c = blank_cmd(OP_RECT);
		c.xs = 40; c.ys = 20; c.w = -10; c.h = 15; send_cmd(c);
		read_at(30, 35);
		c = blank_cmd(OP_FILL);
		c.xs = 120; c.ys = 60; c.w = 20; c.h = 20; send_cmd(c);
		c.xs = 5; c.ys = 5; c.w = 0; c.h = 4; send_cmd(c);
		read_at(125, 62);
		read_at(5, 5);
	endtask

	task automatic test_glyphs();
		draw_cmd_t c;
		c = blank_cmd(OP_GLYPH);
		c.xs = 50; c.ys = 3; c.code = 8'd90; send_cmd(c);
		read_at(50, 3);
		c.xs = 125; c.ys = 60; c.code = 8'd65; send_cmd(c);
		c.xs = 60; c.ys = 0; c.code = 8'd255; send_cmd(c);
		read_at(60, 0);
	endtask

	task automatic test_clear_and_unused();
		draw_cmd_t c;
		c = blank_cmd(OP_NONE);
		c.ridx = 10'd1023;
		send_cmd(c);
		send_cmd(blank_cmd(OP_CLEAR));
		read_at(50, 3);
	endtask

	task automatic test_random(int count);
		draw_cmd_t c;
		int pick;
		for (int n = 0; n < count; n++) begin
			if (n % 200 == 0)
				no_idle = (n % 400 == 200);
			pick = $urandom_range(0, 99);
			c = blank_cmd(OP_READ);
			c.xs = near_coord(-16, 143);
			c.ys = near_coord(-16, 79);
			c.xe = near_coord(-16, 143);
			c.ye = near_coord(-16, 79);
			c.w = ($urandom_range(0, 31) == 0) ? 10'($urandom)
				: 10'($urandom_range(0, 40) - 12);
			c.h = ($urandom_range(0, 31) == 0) ? 10'($urandom)
				: 10'($urandom_range(0, 30) - 8);
			c.color = 1'($urandom);
			c.code = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(32, 90));
			c.ridx = 10'($urandom);
			if (pick < 36) begin
				c.op = OP_READ;
				if (pick < 24)
					c.ridx = 10'((((last_y + $urandom_range(0, 8)) & 63) / 8) * DISPLAY_WIDTH
						+ ((last_x + $urandom_range(0, 6)) & 127));
			end else if (pick < 50) c.op = OP_PIXEL;
			else if (pick < 64) c.op = OP_LINE;
			else if (pick < 72) c.op = OP_RECT;
			else if (pick < 80) c.op = OP_FILL;
			else if (pick < 93) c.op = OP_GLYPH;
			else if (pick < 96) c.op = OP_CLEAR;
			else c.op = OP_NONE;
			send_cmd(c);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		op = 3'd0;
		x_start = 0; y_start = 0; x_end = 0; y_end = 0;
		rect_width = 0; rect_height = 0;
		color = 1'b0;
		char_code = 8'd0;
		read_index = 10'd0;
		// The engine clears its store after reset, so the shadow starts blank.
		foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pixels();
		test_shapes();
		test_glyphs();
		test_clear_and_unused();
		test_random(1500);
		in_valid <= 1'b0;
		while (pending_done.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
sv/pfde_pkg.sv
sv/pfde_ram.sv
sv/pfde_ctrl.sv
sv/pfde_datapath.sv
sv/page_framebuffer_drawing_engine.sv
sv/pfde_checker.sv
verif/page_framebuffer_drawing_engine_test.sv
